// ===== sv/bvma_pkg.sv =====
package bvma_pkg;

	localparam int unsigned SAMPLE_W = 10;
	localparam int unsigned LEVEL_W  = 8;
	localparam int unsigned DSR_W    = 16;
	localparam int unsigned OFFSET_W = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned NORM_SCALE = 16;
	localparam int unsigned NORM_SHIFT = 4;
	localparam int unsigned SCALED_W = 14;

	localparam logic [CFG_IDX_W-1:0] CFG_VOLT_DIVISOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLT_OFFSET  = 2'd1;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_NORM,
		ST_START_SCALE,
		ST_WAIT_SCALE,
		ST_OUT
	} state_t;

endpackage

// ===== sv/bvma_ring.sv =====
module bvma_ring #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr,
	output logic [bvma_pkg::SAMPLE_W-1:0] rd_data,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [bvma_pkg::SAMPLE_W-1:0] wr_data
);

	logic [bvma_pkg::SAMPLE_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]              valid_q;
	logic [bvma_pkg::SAMPLE_W-1:0] rd_data_q;
	logic                          rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== sv/bvma_div.sv =====
module bvma_div #(
	parameter int unsigned N = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [N-1:0]               dividend,
	input  logic [bvma_pkg::DSR_W-1:0] divisor,
	output logic                       done,
	output logic [N-1:0]               quotient
);

	localparam int unsigned DW = bvma_pkg::DSR_W;
	localparam int unsigned CW = $clog2(N + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [N-1:0]  dvd_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dsr_q;
	logic [DW:0]   shifted;
	logic          fits;

	assign shifted = {rem_q, dvd_q[N-1]};
	assign fits    = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(shifted - {1'b0, dsr_q}) : DW'(shifted);
			dvd_q <= {dvd_q[N-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ===== sv/battery_voltage_moving_average.sv =====
// Boxcar average of battery converter samples, scaled to an 8-bit level.
// Input channel: in_valid / in_stall with adc_sample; a transfer happens on a
// rising edge with in_valid high and in_stall low. Output channel: out_valid /
// out_stall with battery_level, same transfer rule.
// Configuration: cfg_we with cfg_index (0 divisor, 1 offset) and cfg_data; the
// user must write these only while the block is idle, which the block does not
// enforce; other indexes are ignored. One sample is processed at a time: it
// passes the steps READ, NORM, START_SCALE, WAIT_SCALE and OUT, and out_valid
// rises once OUT hands the level to the output register. The restoring divider
// yields one quotient bit per cycle of an N-bit dividend (14 bits for WINDOW up
// to 16, up to 16 bits at 64). Above 16 the division by WINDOW is a reciprocal
// multiplication in the NORM step. The next sample can be taken while the last
// level waits in the output register.
// Reset clears the ring (through per-entry valid bits), sum, pointer, and
// sets divisor 1 and offset 0. A stalled output holds its level, and a new
// finished level waits in the last step until the output register drains.
module battery_voltage_moving_average #(
	parameter int unsigned WINDOW = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [bvma_pkg::SAMPLE_W-1:0]   adc_sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [bvma_pkg::LEVEL_W-1:0]    battery_level,
	input  logic                            cfg_we,
	input  logic [bvma_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bvma_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned SUM_W = $clog2(WINDOW * 1023 + 1);
	localparam int unsigned NUM_W = (SUM_W > bvma_pkg::SCALED_W) ? SUM_W
	                                                             : bvma_pkg::SCALED_W;
	localparam int unsigned MULT  = (WINDOW < bvma_pkg::NORM_SCALE)
	                                ? bvma_pkg::NORM_SCALE / WINDOW : 1;
	localparam bit          WIDE  = WINDOW > bvma_pkg::NORM_SCALE;
	localparam int unsigned RCP_SH = SUM_W + AW;
	localparam int unsigned RCP_W  = SUM_W + 1;
	localparam int unsigned PRD_W  = SUM_W + RCP_W;
	localparam logic [RCP_W-1:0] RCP = RCP_W'(((64'd1 << RCP_SH) + 64'(WINDOW) - 64'd1)
	                                          / 64'(WINDOW));

	bvma_pkg::state_t state_q, state_d;

	logic [bvma_pkg::DSR_W-1:0]    divisor_q;
	logic [bvma_pkg::OFFSET_W-1:0] offset_q;
	logic [AW-1:0]                 ptr_q;
	logic [SUM_W-1:0]              sum_q;
	logic [bvma_pkg::SAMPLE_W-1:0] sample_q;
	logic [NUM_W-1:0]              scaled_q;
	logic [NUM_W-1:0]              quot_q;
	logic                          out_valid_q;
	logic [bvma_pkg::LEVEL_W-1:0]  level_q;

	logic                          in_xfer;
	logic                          out_free;
	logic [bvma_pkg::SAMPLE_W-1:0] old_sample;
	logic                          ring_wr;
	logic                          div_start;
	logic [NUM_W-1:0]              div_dividend;
	logic [bvma_pkg::DSR_W-1:0]    div_divisor;
	logic                          div_done;
	logic [NUM_W-1:0]              div_quot;
	logic [NUM_W:0]                level_sum;
	logic [AW-1:0]                 ptr_next;
	logic [PRD_W-1:0]              norm_prod;

	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign ptr_next = (ptr_q == AW'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
	assign norm_prod = PRD_W'(sum_q) * PRD_W'(RCP);

	bvma_ring #(
		.DEPTH(WINDOW),
		.AW   (AW)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (in_xfer),
		.rd_addr(ptr_q),
		.rd_data(old_sample),
		.wr_en  (ring_wr),
		.wr_addr(ptr_q),
		.wr_data(sample_q)
	);

	bvma_div #(
		.N(NUM_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_quot)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bvma_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_d = bvma_pkg::ST_READ;
				end
			end
			bvma_pkg::ST_READ:        state_d = bvma_pkg::ST_NORM;
			bvma_pkg::ST_NORM:        state_d = bvma_pkg::ST_START_SCALE;
			bvma_pkg::ST_START_SCALE: state_d = bvma_pkg::ST_WAIT_SCALE;
			bvma_pkg::ST_WAIT_SCALE: begin
				if (div_done) begin
					state_d = bvma_pkg::ST_OUT;
				end
			end
			bvma_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = bvma_pkg::ST_IDLE;
				end
			end
			default: state_d = bvma_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall     = 1'b1;
		ring_wr      = 1'b0;
		div_start    = 1'b0;
		div_dividend = scaled_q;
		div_divisor  = (divisor_q == '0) ? bvma_pkg::DSR_W'(1) : divisor_q;
		unique case (state_q)
			bvma_pkg::ST_IDLE:  in_stall = 1'b0;
			bvma_pkg::ST_READ:  ring_wr  = 1'b1;
			bvma_pkg::ST_START_SCALE: div_start = 1'b1;
			default: ;
		endcase
	end

	assign level_sum = {1'b0, quot_q} + (NUM_W + 1)'(offset_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bvma_pkg::ST_IDLE;
			divisor_q   <= bvma_pkg::DSR_W'(1);
			offset_q    <= '0;
			ptr_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == bvma_pkg::CFG_VOLT_DIVISOR) begin
					divisor_q <= cfg_data;
				end else if (cfg_index == bvma_pkg::CFG_VOLT_OFFSET) begin
					offset_q <= cfg_data[bvma_pkg::OFFSET_W-1:0];
				end
			end
			if (state_q == bvma_pkg::ST_READ) begin
				sum_q <= sum_q + SUM_W'(sample_q) - SUM_W'(old_sample);
				ptr_q <= ptr_next;
			end
			if (state_q == bvma_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_q <= adc_sample;
		end
		if (state_q == bvma_pkg::ST_NORM) begin
			if (WIDE) begin
				scaled_q <= NUM_W'(norm_prod >> RCP_SH) << bvma_pkg::NORM_SHIFT;
			end else begin
				scaled_q <= NUM_W'(sum_q) * NUM_W'(MULT);
			end
		end
		if (state_q == bvma_pkg::ST_WAIT_SCALE && div_done) begin
			quot_q <= div_quot;
		end
		if (state_q == bvma_pkg::ST_OUT && out_free) begin
			level_q <= (level_sum > (NUM_W + 1)'(bvma_pkg::LEVEL_MAX))
			           ? bvma_pkg::LEVEL_MAX : level_sum[bvma_pkg::LEVEL_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign battery_level = level_q;

endmodule
